// ===== hdl/mqud_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqud_pkg: shared types and codes of the multi-queue urgent deque
// Request and response payloads, result codes and the per-queue control group.
// ----------------------------------------------------------------------------
package mqud_pkg;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [1:0] RES_ADDED = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_TAKEN = 2'd2;
  localparam logic [1:0] RES_EMPTY = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  queue_sel;
    logic [15:0] item_id;
    logic        urgent;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] out_id;
    logic        out_urgent;
    logic [3:0]  fill_after;
  } rsp_t;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/multi_queue_urgent_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_urgent_deque: set of bounded deques with urgent push at head
// Adds append at the tail or, when urgent, push at the head; takes pop the
// head. One response per request with a result code and the new fill count.
// ----------------------------------------------------------------------------
// The block accepts one request in every cycle unless a held response stalls.
// Each request is decided in the cycle it transfers, from the addressed queue's
// fill counter and the head cell of its chain, and its response is held in an
// output register that is shown the next cycle; a request is taken whenever that
// register is empty or drains in the same cycle. No clearing pass follows reset.
module multi_queue_urgent_deque #(
  parameter int NUM_QUEUES  = 32,
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_WIDTH    = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  input  wire mqud_pkg::req_t req,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  output mqud_pkg::rsp_t   rsp
);
  import mqud_pkg::*;

  localparam int STORE_W = (ID_WIDTH < 16) ? ID_WIDTH : 16;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  logic [FILL_W-1:0]  row_fill     [NUM_QUEUES];
  logic [STORE_W-1:0] row_head_id  [NUM_QUEUES];
  logic               row_head_urg [NUM_QUEUES];
  cell_ctrl_t         row_ctrl     [NUM_QUEUES];

  logic               accept;
  logic               in_range;
  logic [QIDX_W-1:0]  qidx;
  logic [FILL_W-1:0]  fill_cur;
  logic               full;
  logic               empty;
  logic [STORE_W-1:0] new_id;
  cell_ctrl_t         op;
  rsp_t               rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign in_range  = (7'(req.queue_sel) < 7'(NUM_QUEUES));
  assign qidx      = QIDX_W'(req.queue_sel);
  assign fill_cur  = in_range ? row_fill[qidx] : '0;
  assign full      = (fill_cur == FILL_W'(QUEUE_DEPTH));
  assign empty     = (fill_cur == '0);
  assign new_id    = req.item_id[STORE_W-1:0];

  always_comb begin
    op       = '0;
    rsp_next = '0;
    if (!in_range) begin
      rsp_next.result_code = (req.cmd == CMD_TAKE) ? RES_EMPTY : RES_FULL;
    end else if (req.cmd == CMD_ADD) begin
      if (full) begin
        rsp_next.result_code = RES_FULL;
        rsp_next.fill_after  = 4'(fill_cur);
      end else begin
        rsp_next.result_code = RES_ADDED;
        rsp_next.fill_after  = 4'(fill_cur + FILL_W'(1));
        op.push_front        = req.urgent;
        op.push_back         = !req.urgent;
      end
    end else begin
      if (empty) begin
        rsp_next.result_code = RES_EMPTY;
      end else begin
        rsp_next.result_code = RES_TAKEN;
        rsp_next.out_id      = 16'(row_head_id[qidx]);
        rsp_next.out_urgent  = row_head_urg[qidx];
        rsp_next.fill_after  = 4'(fill_cur - FILL_W'(1));
        op.pop_front         = 1'b1;
      end
    end
  end

  for (genvar r = 0; r < NUM_QUEUES; r++) begin : g_queue
    assign row_ctrl[r] = (accept && in_range && qidx == QIDX_W'(r)) ? op : '0;

    mqud_row #(
      .DEPTH  (QUEUE_DEPTH),
      .W      (STORE_W),
      .FILL_W (FILL_W)
    ) u_row (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (row_ctrl[r]),
      .new_id   (new_id),
      .fill     (row_fill[r]),
      .head_id  (row_head_id[r]),
      .head_urg (row_head_urg[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_rsp_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request produced no response");

  a_take_hit : assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_TAKE && in_range && !empty)
      |=> rsp.result_code == RES_TAKEN)
    else $error("take from a non-empty queue not reported as taken");

  a_idle_payload : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_code != RES_TAKEN) |-> (rsp.out_id == '0 && !rsp.out_urgent))
    else $error("non-take response carries an item");

endmodule
`default_nettype wire

// ===== hdl/mqud_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqud_cell: one entry slot of a queue row
// Takes its head-side neighbor's entry (slot 0: the new item) on a front push,
// its tail-side neighbor's on a pop, or the new item when it is the tail slot.
// ----------------------------------------------------------------------------
module mqud_cell #(
  parameter int W = 16
) (
  input  wire                      clk,
  input  wire mqud_pkg::cell_ctrl_t ctrl,
  input  wire                      tail_hit,
  input  wire [W-1:0]              new_id,
  input  wire [W-1:0]              prev_id,
  input  wire                      prev_urg,
  input  wire [W-1:0]              next_id,
  input  wire                      next_urg,
  output logic [W-1:0]             id,
  output logic                     urg
);
  import mqud_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      id  <= prev_id;
      urg <= prev_urg;
    end else if (ctrl.pop_front) begin
      id  <= next_id;
      urg <= next_urg;
    end else if (ctrl.push_back && tail_hit) begin
      id  <= new_id;
      urg <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mqud_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqud_row: one bounded deque as a chain of entry cells
// Slot 0 is the head. Holds the fill count and shifts entries along the chain.
// ----------------------------------------------------------------------------
module mqud_row #(
  parameter int DEPTH  = 8,
  parameter int W      = 16,
  parameter int FILL_W = 4
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire mqud_pkg::cell_ctrl_t ctrl,
  input  wire [W-1:0]              new_id,
  output logic [FILL_W-1:0]        fill,
  output logic [W-1:0]             head_id,
  output logic                     head_urg
);
  import mqud_pkg::*;

  logic [W-1:0] ids  [DEPTH];
  logic         urgs [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [W-1:0] prev_id;
    logic         prev_urg;
    logic [W-1:0] next_id;
    logic         next_urg;
    logic         tail_hit;

    if (i == 0) begin : g_head
      assign prev_id  = new_id;
      assign prev_urg = 1'b1;
    end else begin : g_body
      assign prev_id  = ids[i-1];
      assign prev_urg = urgs[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_id  = ids[i];
      assign next_urg = urgs[i];
    end else begin : g_inner
      assign next_id  = ids[i+1];
      assign next_urg = urgs[i+1];
    end

    assign tail_hit = (fill == FILL_W'(i));

    mqud_cell #(.W(W)) u_entry (
      .clk      (clk),
      .ctrl     (ctrl),
      .tail_hit (tail_hit),
      .new_id   (new_id),
      .prev_id  (prev_id),
      .prev_urg (prev_urg),
      .next_id  (next_id),
      .next_urg (next_urg),
      .id       (ids[i]),
      .urg      (urgs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.push_front || ctrl.push_back) begin
      fill <= fill + FILL_W'(1);
    end else if (ctrl.pop_front) begin
      fill <= fill - FILL_W'(1);
    end
  end

  assign head_id  = ids[0];
  assign head_urg = urgs[0];

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue fill count exceeds its depth");

  a_one_op : assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.push_front, ctrl.push_back, ctrl.pop_front}))
    else $error("more than one operation on a queue in one cycle");

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    (ctrl.push_front || ctrl.push_back) |-> fill != FILL_W'(DEPTH))
    else $error("push into a full queue");

endmodule
`default_nettype wire
